// ===== rtl/twtrat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtrat_pkg
// Shared types and codes for the wake-time agreement responder table.
// ----------------------------------------------------------------------------
package twtrat_pkg;

    localparam int NUM_SLOTS_DEF = 8;

    localparam int PEER_W  = 48;
    localparam int AGR_W   = 120;
    localparam int ENTRY_W = PEER_W + AGR_W;

    // command codes
    localparam logic [2:0] CMD_SETUP_ASSOC  = 3'd0;
    localparam logic [2:0] CMD_SETUP_ACTION = 3'd1;
    localparam logic [2:0] CMD_QUERY        = 3'd2;
    localparam logic [2:0] CMD_INSTALL      = 3'd3;
    localparam logic [2:0] CMD_FREE         = 3'd4;

    // status codes
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_DISABLED  = 3'd1;
    localparam logic [2:0] STS_REJECTED  = 3'd2;
    localparam logic [2:0] STS_FULL      = 3'd3;
    localparam logic [2:0] STS_NOT_FOUND = 3'd4;
    localparam logic [2:0] STS_BAD_STATE = 3'd5;

    // setup command field values
    localparam logic [2:0] SETUP_REQUEST = 3'd0;
    localparam logic [2:0] SETUP_SUGGEST = 3'd1;
    localparam logic [2:0] SETUP_ACCEPT  = 3'd4;

    typedef enum logic [1:0] {
        SLOT_EMPTY     = 2'd0,
        SLOT_PENDING   = 2'd1,
        SLOT_INSTALLED = 2'd2
    } slot_state_t;

    typedef enum logic [2:0] {
        SEQ_IDLE = 3'b001,
        SEQ_SCAN = 3'b010,
        SEQ_RESP = 3'b100
    } seq_state_t;

    // stored agreement fields, 120 bits
    typedef struct packed {
        logic [7:0]  channel;
        logic [15:0] mantissa;
        logic [7:0]  min_duration;
        logic [63:0] wake_time;
        logic [15:0] req_type;
        logic [7:0]  control;
    } agr_t;

    typedef struct packed {
        agr_t       agr;
        logic       element_valid;
        logic [2:0] slot;
        logic [2:0] status;
    } result_t;

endpackage

// ===== rtl/twt_responder_agreement_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twt_responder_agreement_table
// Responder-side table of wake-time agreements keyed by peer address.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tuser: cmd; tdata: request fields
//  m_*       out        m_tvalid/m_tready  tuser: element_valid; tdata: result
//  cfg_*     in         cfg_we             responder_enable
//
//  During a scan one slot per cycle goes through the single address
//  comparator against the entry RAM, which is read one slot ahead.
//  Disabled and rejected commands skip the scan; an undefined command
//  is dropped in its accept cycle.
//  Reset empties every slot at once through the per-slot state flops.
//  A stalled result keeps the next result, and so the table, busy until it is taken.
// ----------------------------------------------------------------------------
module twt_responder_agreement_table #(
    parameter int NUM_SLOTS = twtrat_pkg::NUM_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [2:0] cmd
    input  logic [2:0]   s_tuser,
    // [47:0] peer_addr, [63:48] req_type, [71:64] control_in,
    // [135:72] wake_time_in, [143:136] min_duration_in, [159:144] mantissa_in,
    // [167:160] channel_in
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] element_valid
    output logic [0:0]   m_tuser,
    // [2:0] status, [5:3] slot, [13:6] control_out, [29:14] req_type_out,
    // [93:30] wake_time_out, [101:94] min_duration_out, [117:102] mantissa_out,
    // [125:118] channel_out, [127:126] zero
    output logic [127:0] m_tdata
);

    import twtrat_pkg::*;

    localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_SLOTS - 1);

    seq_state_t        seq_reg, seq_next;
    logic              enable_reg;
    logic [2:0]        cmd_reg, cmd_next;
    logic [PEER_W-1:0] peer_reg, peer_next;
    agr_t              agr_reg, agr_next;
    logic [IDXW-1:0]   scan_idx_reg, scan_idx_next;
    logic              empty_found_reg, empty_found_next;
    logic [IDXW-1:0]   empty_idx_reg, empty_idx_next;
    result_t           res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    slot_state_t       slot_state_reg [NUM_SLOTS];
    slot_state_t       slot_state_next [NUM_SLOTS];

    logic               ram_we;
    logic [IDXW-1:0]    ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDXW-1:0]    ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic              s_accept;
    slot_state_t       cur_state;
    logic              cur_empty;
    logic              hit;
    logic              last;
    agr_t              in_agr;
    agr_t              acc_agr;
    logic [2:0]        setup_code;

    function automatic logic [2:0] slot_code(input logic [IDXW-1:0] idx);
        logic [IDXW+2:0] wide;
        wide = {3'b000, idx};
        return wide[2:0];
    endfunction

    twtrat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (seq_reg == SEQ_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign in_agr.control      = s_tdata[71:64];
    assign in_agr.req_type     = s_tdata[63:48];
    assign in_agr.wake_time    = s_tdata[135:72];
    assign in_agr.min_duration = s_tdata[143:136];
    assign in_agr.mantissa     = s_tdata[159:144];
    assign in_agr.channel      = s_tdata[167:160];
    assign setup_code          = s_tdata[51:49];

    // accept form: request bit cleared, setup command set to accept
    always_comb
    begin
        acc_agr = agr_reg;
        acc_agr.req_type = {agr_reg.req_type[15:4], SETUP_ACCEPT, 1'b0};
    end

    assign cur_state = slot_state_reg[scan_idx_reg];
    assign cur_empty = (cur_state == SLOT_EMPTY);
    assign hit       = !cur_empty && (ram_rdata[ENTRY_W-1:AGR_W] == peer_reg);
    assign last      = (scan_idx_reg == LAST_IDX);

    // read one slot ahead of the compare
    assign ram_raddr = (seq_reg == SEQ_SCAN && !last) ? scan_idx_reg + 1'b1 : '0;
    assign ram_wdata = {peer_reg, acc_agr};

    always_comb
    begin
        logic            have_tgt;
        logic [IDXW-1:0] tgt;

        seq_next         = seq_reg;
        cmd_next         = cmd_reg;
        peer_next        = peer_reg;
        agr_next         = agr_reg;
        scan_idx_next    = scan_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        slot_state_next  = slot_state_reg;
        ram_we           = 1'b0;
        ram_waddr        = scan_idx_reg;
        have_tgt         = 1'b0;
        tgt              = scan_idx_reg;

        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (s_accept)
                begin
                    cmd_next         = s_tuser;
                    peer_next        = s_tdata[47:0];
                    agr_next         = in_agr;
                    scan_idx_next    = '0;
                    empty_found_next = 1'b0;
                    res_next         = '0;
                    priority if (s_tuser > CMD_FREE)
                    begin
                        // undefined command: drop silently
                        seq_next = SEQ_IDLE;
                    end
                    else if (!enable_reg)
                    begin
                        res_next.status = STS_DISABLED;
                        seq_next        = SEQ_RESP;
                    end
                    else if ((s_tuser == CMD_SETUP_ASSOC || s_tuser == CMD_SETUP_ACTION) &&
                             setup_code != SETUP_REQUEST && setup_code != SETUP_SUGGEST)
                    begin
                        res_next.status = STS_REJECTED;
                        seq_next        = SEQ_RESP;
                    end
                    else
                    begin
                        seq_next = SEQ_SCAN;
                    end
                end
            end

            SEQ_SCAN:
            begin
                if (cur_empty && !empty_found_reg)
                begin
                    empty_found_next = 1'b1;
                    empty_idx_next   = scan_idx_reg;
                end
                scan_idx_next = scan_idx_reg + 1'b1;
                if (hit || last)
                begin
                    seq_next = SEQ_RESP;
                    res_next = '0;
                    if (cmd_reg == CMD_SETUP_ASSOC || cmd_reg == CMD_SETUP_ACTION)
                    begin
                        priority if (hit)
                        begin
                            have_tgt = 1'b1;
                            tgt      = scan_idx_reg;
                        end
                        else if (empty_found_reg)
                        begin
                            have_tgt = 1'b1;
                            tgt      = empty_idx_reg;
                        end
                        else if (cur_empty)
                        begin
                            have_tgt = 1'b1;
                            tgt      = scan_idx_reg;
                        end
                        if (have_tgt)
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = tgt;
                            slot_state_next[tgt] = (cmd_reg == CMD_SETUP_ASSOC) ?
                                                   SLOT_PENDING : SLOT_INSTALLED;
                            res_next.status = STS_OK;
                            res_next.slot   = slot_code(tgt);
                            if (cmd_reg == CMD_SETUP_ACTION)
                            begin
                                res_next.element_valid = 1'b1;
                                res_next.agr           = acc_agr;
                            end
                        end
                        else
                        begin
                            res_next.status = STS_FULL;
                        end
                    end
                    else if (!hit)
                    begin
                        res_next.status = STS_NOT_FOUND;
                    end
                    else
                    begin
                        res_next.slot = slot_code(scan_idx_reg);
                        if (cmd_reg == CMD_FREE)
                        begin
                            if (cur_state == SLOT_INSTALLED)
                            begin
                                res_next.status = STS_OK;
                                slot_state_next[scan_idx_reg] = SLOT_EMPTY;
                            end
                            else
                            begin
                                res_next.status = STS_BAD_STATE;
                            end
                        end
                        else if (cur_state != SLOT_PENDING)
                        begin
                            res_next.status = STS_BAD_STATE;
                        end
                        else
                        begin
                            res_next.status = STS_OK;
                            if (cmd_reg == CMD_QUERY)
                            begin
                                res_next.element_valid = 1'b1;
                                res_next.agr           = ram_rdata[AGR_W-1:0];
                            end
                            else
                            begin
                                slot_state_next[scan_idx_reg] = SLOT_INSTALLED;
                            end
                        end
                    end
                end
            end

            SEQ_RESP:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    seq_next       = SEQ_IDLE;
                end
            end

            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg          <= SEQ_IDLE;
            enable_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            scan_idx_reg     <= '0;
            empty_found_reg  <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_state_reg[i] <= SLOT_EMPTY;
            end
        end
        else
        begin
            seq_reg         <= seq_next;
            out_valid_reg   <= out_valid_next;
            scan_idx_reg    <= scan_idx_next;
            empty_found_reg <= empty_found_next;
            slot_state_reg  <= slot_state_next;
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        peer_reg      <= peer_next;
        agr_reg       <= agr_next;
        empty_idx_reg <= empty_idx_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_reg.element_valid;
    assign m_tdata    = {2'b00,
                         out_reg.agr.channel,
                         out_reg.agr.mantissa,
                         out_reg.agr.min_duration,
                         out_reg.agr.wake_time,
                         out_reg.agr.req_type,
                         out_reg.agr.control,
                         out_reg.slot,
                         out_reg.status};

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SEQ_SCAN |-> scan_idx_reg <= LAST_IDX)
        else $error("scan index beyond last slot");

    a_no_element_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[125:6] == '0)
        else $error("agreement fields not zero without element");

    a_resp_waits: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SEQ_RESP && m_tvalid && !m_tready |=> seq_reg == SEQ_RESP)
        else $error("result overwrote a stalled response");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SEQ_SCAN |=> !s_tready || $past(hit) || $past(last))
        else $error("ready raised during a scan");
`endif

endmodule

// ===== rtl/twtrat_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtrat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twtrat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wake-time agreement responder table. Requests
// are driven on the input stream and checked on the result stream. A model
// of the slot table predicts each result. The stimulus is a directed pass
// over status codes and field extremes, then phases of random setup, query,
// install and free sequences. The enable register changes between phases.
// ----------------------------------------------------------------------------
module testbench;
    import twtrat_pkg::*;

    localparam int TBL_SLOTS     = NUM_SLOTS_DEF;
    localparam int SETTLE_CYCLES = 2 * TBL_SLOTS + 8;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 270;

    // command codes outside the defined set
    localparam logic [2:0] CMD_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNDEF_LAST  = 3'd7;

    // request fields packed as on s_tdata, peer address in the low bits
    typedef struct packed {
        logic [7:0]  channel;
        logic [15:0] mantissa;
        logic [7:0]  min_duration;
        logic [63:0] wake_time;
        logic [7:0]  control;
        logic [15:0] req_type;
        logic [47:0] peer;
    } twt_req_t;

    typedef struct {
        logic [2:0] cmd;
        twt_req_t   fields;
        int         gap;
    } queued_req_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [2:0]   s_tuser = '0;
    logic [167:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [0:0]   m_tuser;
    logic [127:0] m_tdata;

    twt_responder_agreement_table #(
        .NUM_SLOTS(TBL_SLOTS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // table model
    bit          tbl_enable = 1'b0;
    slot_state_t tbl_state[TBL_SLOTS];
    logic [47:0] tbl_peer[TBL_SLOTS];
    agr_t        tbl_agr[TBL_SLOTS];

    queued_req_t pending_reqs[$];
    result_t     awaited_responses[$];
    int          mismatches = 0;
    int          sent_count = 0;
    int          gap_max = 0;
    int          rx_stall_max = 0;
    bit          long_hold_go = 1'b0;
    logic [47:0] peer_pool[12];

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < TBL_SLOTS; i++)
        begin
            tbl_state[i] = SLOT_EMPTY;
            tbl_peer[i]  = '0;
            tbl_agr[i]   = '0;
        end
    end

    function automatic bit agreement_response(input logic [2:0] cmd, input twt_req_t rq,
                                              output result_t rsp);
        int hit;
        int idx;
        logic [2:0] setup;
        rsp = '0;
        if (cmd > CMD_FREE)
            return 1'b0;
        if (!tbl_enable)
        begin
            rsp.status = STS_DISABLED;
            return 1'b1;
        end
        hit = -1;
        for (int i = 0; i < TBL_SLOTS; i++)
            if (hit < 0 && tbl_state[i] != SLOT_EMPTY && tbl_peer[i] == rq.peer)
                hit = i;
        if (cmd == CMD_SETUP_ASSOC || cmd == CMD_SETUP_ACTION)
        begin
            setup = rq.req_type[3:1];
            if (setup != SETUP_REQUEST && setup != SETUP_SUGGEST)
            begin
                rsp.status = STS_REJECTED;
                return 1'b1;
            end
            idx = hit;
            for (int i = 0; i < TBL_SLOTS; i++)
                if (idx < 0 && tbl_state[i] == SLOT_EMPTY)
                    idx = i;
            if (idx < 0)
            begin
                rsp.status = STS_FULL;
                return 1'b1;
            end
            tbl_peer[idx]               = rq.peer;
            tbl_agr[idx].control        = rq.control;
            tbl_agr[idx].req_type       = {rq.req_type[15:4], SETUP_ACCEPT, 1'b0};
            tbl_agr[idx].wake_time      = rq.wake_time;
            tbl_agr[idx].min_duration   = rq.min_duration;
            tbl_agr[idx].mantissa       = rq.mantissa;
            tbl_agr[idx].channel        = rq.channel;
            tbl_state[idx] = (cmd == CMD_SETUP_ASSOC) ? SLOT_PENDING : SLOT_INSTALLED;
            rsp.status = STS_OK;
            rsp.slot   = idx[2:0];
            if (cmd == CMD_SETUP_ACTION)
            begin
                rsp.element_valid = 1'b1;
                rsp.agr           = tbl_agr[idx];
            end
            return 1'b1;
        end
        if (hit < 0)
        begin
            rsp.status = STS_NOT_FOUND;
            return 1'b1;
        end
        rsp.slot = hit[2:0];
        if (cmd == CMD_FREE)
        begin
            if (tbl_state[hit] != SLOT_INSTALLED)
            begin
                rsp.status = STS_BAD_STATE;
                return 1'b1;
            end
            tbl_state[hit] = SLOT_EMPTY;
            tbl_peer[hit]  = '0;
            tbl_agr[hit]   = '0;
            rsp.status     = STS_OK;
            return 1'b1;
        end
        if (tbl_state[hit] != SLOT_PENDING)
        begin
            rsp.status = STS_BAD_STATE;
            return 1'b1;
        end
        rsp.status = STS_OK;
        if (cmd == CMD_QUERY)
        begin
            rsp.element_valid = 1'b1;
            rsp.agr           = tbl_agr[hit];
        end
        else
            tbl_state[hit] = SLOT_INSTALLED;
        return 1'b1;
    endfunction

    // driver: one request in flight, gap counted before each new one
    int          gap_count = 0;
    queued_req_t cur_req;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_count = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_reqs.size() != 0 && gap_count >= pending_reqs[0].gap)
            begin
                cur_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_req.cmd;
                s_tdata  <= cur_req.fields;
                gap_count = 0;
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (pending_reqs.size() != 0)
                    gap_count++;
            end
        end
    end

    // receiver: random stall after each result, plus one long hold-off
    int stall_left = 0;
    int long_hold_left = 0;
    bit long_hold_started = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                stall_left = (rx_stall_max > 0) ? $urandom_range(0, rx_stall_max) : 0;
            if (long_hold_go && !long_hold_started)
            begin
                long_hold_started = 1'b1;
                long_hold_left    = LONG_HOLD;
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // monitor: check results first, then predict from the accepted request
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        result_t predicted;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status        = m_tdata[2:0];
                got.slot          = m_tdata[5:3];
                got.agr           = m_tdata[125:6];
                got.element_valid = m_tuser[0];
                if (awaited_responses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d slot %0d", got.status,
                                 got.slot);
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.element_valid !== want.element_valid ||
                        got.agr.control !== want.agr.control ||
                        got.agr.req_type !== want.agr.req_type ||
                        got.agr.wake_time !== want.agr.wake_time ||
                        got.agr.min_duration !== want.agr.min_duration ||
                        got.agr.mantissa !== want.agr.mantissa ||
                        got.agr.channel !== want.agr.channel)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected status %0d slot %0d elem %0b agr %h",
                                     want.status, want.slot, want.element_valid, want.agr);
                            $display("          actual   status %0d slot %0d elem %0b agr %h",
                                     got.status, got.slot, got.element_valid, got.agr);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                if (agreement_response(s_tuser, s_tdata, predicted))
                    awaited_responses.push_back(predicted);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic twt_req_t random_fields(input logic [47:0] peer, input bit legal_setup);
        twt_req_t rq;
        rq.peer         = peer;
        rq.req_type     = 16'($urandom);
        if (legal_setup)
            rq.req_type[3:1] = $urandom_range(0, 1) ? SETUP_SUGGEST : SETUP_REQUEST;
        rq.control      = 8'($urandom);
        rq.wake_time    = {$urandom, $urandom};
        rq.min_duration = 8'($urandom);
        rq.mantissa     = 16'($urandom);
        rq.channel      = 8'($urandom);
        return rq;
    endfunction

    task automatic push_req(input logic [2:0] cmd, input twt_req_t rq);
        queued_req_t item;
        item.cmd    = cmd;
        item.fields = rq;
        item.gap    = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        pending_reqs.push_back(item);
        if (cmd <= CMD_FREE)
            sent_count++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || awaited_responses.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_enable(input bit value);
        wait_idle();
        // ignored commands leave no result behind, so let any scan finish
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        tbl_enable = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // well-formed sequences on a small peer pool, with noise mixed in
    task automatic fill_sequences(input int count);
        int          target;
        int          steps;
        logic [47:0] peer;
        logic [2:0]  cmd;
        target = sent_count + count;
        while (sent_count < target)
        begin
            peer = peer_pool[$urandom_range(0, 11)];
            if ($urandom_range(0, 99) < 75)
            begin
                steps = $urandom_range(1, 4);
                push_req($urandom_range(0, 3) == 0 ? CMD_SETUP_ACTION : CMD_SETUP_ASSOC,
                         random_fields(peer, $urandom_range(0, 9) != 0));
                if (steps > 1)
                    push_req(CMD_QUERY, random_fields(peer, 1'b1));
                if (steps > 2)
                    push_req(CMD_INSTALL, random_fields(peer, 1'b1));
                if (steps > 3)
                    push_req(CMD_FREE, random_fields(peer, 1'b1));
            end
            else
            begin
                cmd = 3'($urandom_range(0, 7));
                if (cmd > CMD_SETUP_ACTION && $urandom_range(0, 1))
                    peer = 48'({$urandom, $urandom});
                push_req(cmd, random_fields(peer, $urandom_range(0, 1) != 0));
            end
        end
    endtask

    initial
    begin
        twt_req_t rq;
        peer_pool[0] = '0;
        peer_pool[1] = '1;
        for (int i = 2; i < 12; i++)
            peer_pool[i] = 48'({$urandom, $urandom});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // responder off after reset: every defined command reports disabled, an undefined one is dropped
        for (int c = CMD_SETUP_ASSOC; c <= CMD_FREE + 1; c++)
            push_req(3'(c), random_fields(peer_pool[2], 1'b1));
        write_enable(1'b1);

        // directed pass
        rq = '1;
        rq.req_type = 16'hFFF3;
        push_req(CMD_SETUP_ASSOC, rq);
        push_req(CMD_QUERY, rq);
        push_req(CMD_INSTALL, rq);
        push_req(CMD_QUERY, rq);
        push_req(CMD_FREE, rq);
        push_req(CMD_FREE, rq);
        rq = '0;
        push_req(CMD_SETUP_ACTION, rq);
        push_req(CMD_SETUP_ASSOC, random_fields('0, 1'b1));
        push_req(CMD_FREE, rq);
        rq.req_type = 16'h000E;
        push_req(CMD_SETUP_ASSOC, rq);
        push_req(CMD_QUERY, random_fields(peer_pool[11], 1'b1));
        push_req(CMD_INSTALL, random_fields(peer_pool[10], 1'b1));
        push_req(CMD_UNDEF_FIRST, random_fields(peer_pool[3], 1'b1));
        push_req(CMD_UNDEF_LAST, random_fields('0, 1'b1));
        for (int i = 2; i < 9; i++)
            push_req(CMD_SETUP_ACTION, random_fields(peer_pool[i], 1'b1));
        push_req(CMD_SETUP_ASSOC, random_fields(peer_pool[9], 1'b1));
        push_req(CMD_QUERY, random_fields('0, 1'b1));
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            gap_max      = (ph % 2 == 0) ? 16 : 0;
            rx_stall_max = (ph % 3 == 1) ? 0 : 16;
            if (ph == 2)
            begin
                // stream back to back while the receiver holds off
                gap_max      = 0;
                long_hold_go = 1'b1;
            end
            if (ph == 3)
            begin
                write_enable(1'b0);
                fill_sequences(60);
                write_enable(1'b1);
            end
            else
            begin
                fill_sequences(PHASE_ITEMS);
                wait_idle();
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_responses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
